/* rtl/scb_pkg.sv */
// scb_pkg: shared widths, constants and pipeline item type for the sphere/box contact core
// no dependencies
package scb_pkg;

  localparam int CW      = 32;   // coordinate width
  localparam int RW      = 31;   // radius, half extent and depth width
  localparam int D2W     = 2 * RW;
  localparam int NW      = 16;   // normal component width
  localparam int QW      = 15;   // normal magnitude quotient width
  localparam int NSHIFT  = 14;   // normal scale is 2^14
  localparam int NUMW    = RW + NSHIFT + 1;
  localparam int CFGW    = 16;

  localparam logic [CFGW-1:0] MIN_DISTANCE_RESET = 16'd7;
  localparam logic [NW-1:0]   NORMAL_ONE         = 16'd16384;

  localparam int FRONT_LAT = 4;
  localparam int SQRT_LAT  = RW;
  localparam int DIV_LAT   = QW + 2;
  localparam int LATENCY   = FRONT_LAT + SQRT_LAT + DIV_LAT;

  typedef struct packed {
    logic                  hit;
    logic [RW-1:0]         radius;
    logic [2:0][RW-1:0]    mag;
    logic [2:0]            neg;
  } scb_item_t;

endpackage

/* rtl/scb_front.sv */
// scb_front: clamp into box, per-axis distance, squares and contact compare (4 stages)
// depends on scb_pkg
module scb_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic [2:0][scb_pkg::CW-1:0]            center,
  input  logic [2:0][scb_pkg::CW-1:0]            box_center,
  input  logic [2:0][scb_pkg::RW-1:0]            box_half,
  input  logic [scb_pkg::RW-1:0]                 radius,
  output logic                                   out_valid,
  output scb_pkg::scb_item_t                     out_item,
  output logic [scb_pkg::D2W-1:0]                out_dist2
);

  localparam int EW = scb_pkg::CW + 2;

  // stage a: box bounds
  logic                    va;
  logic signed [EW-1:0]    ca [3];
  logic signed [EW-1:0]    lo [3];
  logic signed [EW-1:0]    hi [3];
  logic [scb_pkg::RW-1:0]  ra;

  // stage b: delta magnitude and far-axis test
  logic                             vb;
  logic [2:0][scb_pkg::RW-1:0]      magb;
  logic [2:0]                       negb;
  logic                             farb;
  logic [scb_pkg::RW-1:0]           rb;

  // stage c: squares
  logic                             vc;
  logic [scb_pkg::D2W-1:0]          sq [3];
  logic [scb_pkg::D2W-1:0]          r2;
  logic [2:0][scb_pkg::RW-1:0]      magc;
  logic [2:0]                       negc;
  logic                             farc;
  logic [scb_pkg::RW-1:0]           rc;

  logic signed [EW-1:0]             p [3];
  logic signed [EW-1:0]             d [3];
  logic [EW-1:0]                    a [3];
  logic [2:0]                       far_ax;
  logic [scb_pkg::D2W+1:0]          sum;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (ca[j] < lo[j]) begin
        p[j] = lo[j];
      end else if (ca[j] > hi[j]) begin
        p[j] = hi[j];
      end else begin
        p[j] = ca[j];
      end
      d[j] = p[j] - ca[j];
      a[j] = d[j][EW-1] ? EW'(-d[j]) : EW'(d[j]);
      far_ax[j] = a[j] >= {3'b000, ra};
    end
  end

  always_comb begin
    sum = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va        <= in_valid;
      vb        <= va;
      vc        <= vb;
      out_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      ca[j] <= EW'($signed(center[j]));
      lo[j] <= EW'($signed(box_center[j])) - $signed({3'b000, box_half[j]});
      hi[j] <= EW'($signed(box_center[j])) + $signed({3'b000, box_half[j]});
    end
    ra <= radius;

    for (int j = 0; j < 3; j++) begin
      magb[j] <= a[j][scb_pkg::RW-1:0];
      negb[j] <= d[j][EW-1];
    end
    farb <= |far_ax;
    rb   <= ra;

    for (int j = 0; j < 3; j++) begin
      sq[j] <= magb[j] * magb[j];
    end
    r2   <= rb * rb;
    magc <= magb;
    negc <= negb;
    farc <= farb;
    rc   <= rb;

    out_item.hit    <= !farc && (sum < {2'b00, r2});
    out_item.radius <= rc;
    out_item.mag    <= magc;
    out_item.neg    <= negc;
    out_dist2       <= sum[scb_pkg::D2W-1:0];
  end

endmodule

/* rtl/scb_sqrt.sv */
// scb_sqrt: pipelined integer square root, one result bit per stage
// depends on scb_pkg
module scb_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  scb_pkg::scb_item_t          in_item,
  input  logic [scb_pkg::D2W-1:0]     in_dist2,
  output logic                        out_valid,
  output scb_pkg::scb_item_t          out_item,
  output logic [scb_pkg::RW-1:0]      out_dist
);

  localparam int STAGES = scb_pkg::RW;

  logic [STAGES:0]                vld;
  scb_pkg::scb_item_t             item [STAGES+1];
  logic [scb_pkg::D2W-1:0]        rem  [STAGES+1];
  logic [scb_pkg::RW-1:0]         root [STAGES+1];

  always_comb begin
    vld[0]  = in_valid;
    item[0] = in_item;
    rem[0]  = in_dist2;
    root[0] = '0;
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int B = STAGES - 1 - s;
    logic [scb_pkg::D2W:0] trial;
    logic                  fits;

    // (root + 2^B)^2 - root^2
    always_comb begin
      trial = ((scb_pkg::D2W+1)'(root[s]) << (B + 1)) + ((scb_pkg::D2W+1)'(1) << (2 * B));
      fits  = {1'b0, rem[s]} >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      item[s+1] <= item[s];
      rem[s+1]  <= fits ? rem[s] - trial[scb_pkg::D2W-1:0] : rem[s];
      root[s+1] <= fits ? (root[s] | (scb_pkg::RW'(1) << B)) : root[s];
    end
  end

  assign out_valid = vld[STAGES];
  assign out_item  = item[STAGES];
  assign out_dist  = root[STAGES];

endmodule

/* rtl/scb_div.sv */
// scb_div: depth, small-distance test and pipelined restoring division for the normal
// depends on scb_pkg
module scb_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  scb_pkg::scb_item_t                in_item,
  input  logic [scb_pkg::RW-1:0]            in_dist,
  input  logic [scb_pkg::CFGW-1:0]          min_distance,
  output logic                              out_valid,
  output logic                              colliding,
  output logic [scb_pkg::RW-1:0]            depth,
  output logic [2:0][scb_pkg::NW-1:0]       normal
);

  localparam int S = scb_pkg::QW;

  logic [S:0]                           vld;
  logic [S:0]                           hit;
  logic [S:0]                           near_up;
  logic [2:0]                           neg   [S+1];
  logic [scb_pkg::RW-1:0]               dep   [S+1];
  logic [scb_pkg::RW-1:0]               dvs   [S+1];
  logic [2:0][scb_pkg::NUMW-1:0]        rr    [S+1];
  logic [2:0][scb_pkg::QW-1:0]          qq    [S+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  // setup: numerator = mag * 2^14 + dist / 2
  always_ff @(posedge clk) begin
    hit[0]     <= in_item.hit;
    near_up[0] <= in_dist <= scb_pkg::RW'(min_distance);
    neg[0]     <= in_item.neg;
    dep[0]     <= in_item.radius - in_dist;
    dvs[0]     <= in_dist;
    for (int j = 0; j < 3; j++) begin
      rr[0][j] <= {1'b0, in_item.mag[j], scb_pkg::NSHIFT'(0)}
                  + scb_pkg::NUMW'(in_dist >> 1);
    end
    qq[0] <= '0;
  end

  for (genvar s = 0; s < S; s++) begin : g_stage
    localparam int K = S - 1 - s;
    logic [scb_pkg::NUMW-1:0] dsh;
    logic [2:0]               ge;

    always_comb begin
      dsh = scb_pkg::NUMW'(dvs[s]) << K;
      for (int j = 0; j < 3; j++) begin
        ge[j] = rr[s][j] >= dsh;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      hit[s+1]     <= hit[s];
      near_up[s+1] <= near_up[s];
      neg[s+1]     <= neg[s];
      dep[s+1]     <= dep[s];
      dvs[s+1]     <= dvs[s];
      for (int j = 0; j < 3; j++) begin
        rr[s+1][j] <= ge[j] ? rr[s][j] - dsh : rr[s][j];
        qq[s+1][j] <= qq[s][j] | (scb_pkg::QW'(ge[j]) << K);
      end
    end
  end

  logic [2:0][scb_pkg::NW-1:0] nrm;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (!hit[S]) begin
        nrm[j] = '0;
      end else if (near_up[S]) begin
        nrm[j] = (j == 1) ? scb_pkg::NORMAL_ONE : '0;
      end else if (neg[S][j]) begin
        nrm[j] = -{1'b0, qq[S][j]};
      end else begin
        nrm[j] = {1'b0, qq[S][j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[S];
    end
  end

  always_ff @(posedge clk) begin
    colliding <= hit[S];
    depth     <= hit[S] ? dep[S] : '0;
    normal    <= nrm;
  end

endmodule

/* rtl/sphere_box_contact_core.sv */
// sphere_box_contact_core: top level of the sphere versus axis-aligned box contact test
// depends on scb_pkg, scb_front, scb_sqrt, scb_div
//
// A transaction is taken on every cycle where start is high and busy is low; busy is only
// high during reset, so one query per clock is sustained. Each query produces exactly one
// result, shown on the result ports for one cycle with done high, after it has passed
// through 4 front stages, 31 square-root stages and 17 divider stages. The receiver
// cannot stall the pipeline. min_distance is written with cfg_wr_en and should change only
// while no query is in flight.
module sphere_box_contact_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [31:0]               sphere_center_x,
  input  logic signed [31:0]               sphere_center_y,
  input  logic signed [31:0]               sphere_center_z,
  input  logic [30:0]                      sphere_radius,
  input  logic signed [31:0]               box_center_x,
  input  logic signed [31:0]               box_center_y,
  input  logic signed [31:0]               box_center_z,
  input  logic [30:0]                      box_half_x,
  input  logic [30:0]                      box_half_y,
  input  logic [30:0]                      box_half_z,
  input  logic                             cfg_wr_en,
  input  logic [15:0]                      cfg_wr_data,
  output logic                             done,
  output logic                             colliding,
  output logic [30:0]                      depth,
  output logic signed [15:0]               normal_x,
  output logic signed [15:0]               normal_y,
  output logic signed [15:0]               normal_z
);

  logic [scb_pkg::CFGW-1:0]           min_distance;
  logic                               f_valid;
  scb_pkg::scb_item_t                 f_item;
  logic [scb_pkg::D2W-1:0]            f_dist2;
  logic                               s_valid;
  scb_pkg::scb_item_t                 s_item;
  logic [scb_pkg::RW-1:0]             s_dist;
  logic [2:0][scb_pkg::NW-1:0]        normal;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= scb_pkg::MIN_DISTANCE_RESET;
    end else if (cfg_wr_en) begin
      min_distance <= cfg_wr_data;
    end
  end

  scb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .center     ({sphere_center_z, sphere_center_y, sphere_center_x}),
    .box_center ({box_center_z, box_center_y, box_center_x}),
    .box_half   ({box_half_z, box_half_y, box_half_x}),
    .radius     (sphere_radius),
    .out_valid  (f_valid),
    .out_item   (f_item),
    .out_dist2  (f_dist2)
  );

  scb_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_item   (f_item),
    .in_dist2  (f_dist2),
    .out_valid (s_valid),
    .out_item  (s_item),
    .out_dist  (s_dist)
  );

  scb_div u_div (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_valid),
    .in_item      (s_item),
    .in_dist      (s_dist),
    .min_distance (min_distance),
    .out_valid    (done),
    .colliding    (colliding),
    .depth        (depth),
    .normal       (normal)
  );

  assign normal_x = normal[0];
  assign normal_y = normal[1];
  assign normal_z = normal[2];

endmodule

/* rtl/scb_checker.sv */
// scb_checker: port-level assertions for sphere_box_contact_core, bound to the top level
// depends on scb_pkg
module scb_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               colliding,
  input logic [30:0]        depth,
  input logic [15:0]        normal_x,
  input logic [15:0]        normal_y,
  input logic [15:0]        normal_z
);

  // every transaction comes back after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(scb_pkg::LATENCY) done)
    else $error("result missing at fixed latency");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, scb_pkg::LATENCY))
    else $error("result without a transaction");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !colliding) |-> (depth == 0 && normal_x == 0 && normal_y == 0 && normal_z == 0))
    else $error("miss with nonzero payload");

  a_hit_depth: assert property (@(posedge clk) disable iff (rst)
    (done && colliding) |-> (depth != 0 && (normal_x != 0 || normal_y != 0 || normal_z != 0)))
    else $error("contact with zero depth or normal");

endmodule

bind sphere_box_contact_core scb_checker u_scb_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .colliding (colliding),
  .depth     (depth),
  .normal_x  (normal_x),
  .normal_y  (normal_y),
  .normal_z  (normal_z)
);
